// File: design/ihex_pkg.sv
// ----------------------------------------------------------------------------
// ihex_pkg: shared types and constants of the HEX record parser
// Character codes, field positions, record types, queue depth, write command word, hex_digit().
// ----------------------------------------------------------------------------
`default_nettype none

package ihex_pkg;

	// character codes
	localparam logic [7:0] ASCII_COLON   = 8'h3A;
	localparam logic [7:0] ASCII_NL      = 8'h0A;
	localparam logic [7:0] ASCII_ZERO    = 8'h30;
	localparam logic [7:0] ASCII_UPPER_A = 8'h41;
	localparam logic [7:0] ASCII_UPPER_F = 8'h46;
	localparam logic [7:0] ASCII_LOWER_A = 8'h61;
	localparam logic [7:0] ASCII_LOWER_F = 8'h66;

	// position within a line, colon at zero
	localparam int unsigned POS_W = 10;
	localparam logic [POS_W-1:0] POS_MAX         = 10'd1023;
	localparam logic [POS_W-1:0] POS_COUNT_FIRST = 10'd1;
	localparam logic [POS_W-1:0] POS_COUNT_LAST  = 10'd2;
	localparam logic [POS_W-1:0] POS_ADDR_FIRST  = 10'd3;
	localparam logic [POS_W-1:0] POS_ADDR_LAST   = 10'd6;
	localparam logic [POS_W-1:0] POS_TYPE_FIRST  = 10'd7;
	localparam logic [POS_W-1:0] POS_TYPE_LAST   = 10'd8;
	localparam logic [POS_W-1:0] POS_DATA_FIRST  = 10'd9;
	localparam logic [POS_W-1:0] POS_OFFSET_LAST = 10'd12;

	// record types
	localparam logic [7:0] REC_DATA    = 8'h00;
	localparam logic [7:0] REC_EXT_SEG = 8'h02;
	localparam logic [7:0] REC_EXT_LIN = 8'h04;

	// depth of the queue between front and back
	localparam int unsigned QUEUE_DEPTH = 4;

	// one pending write, address still in parts
	typedef struct packed {
		logic [15:0] record_address;
		logic [31:0] address_offset;
		logic [7:0]  byte_index;
		logic [7:0]  data;
	} wr_cmd_t;

	// hex digit value; anything else keeps the low nibble of code minus '0'
	function automatic logic [3:0] hex_digit(input logic [7:0] c);
		logic [7:0] diff;
		diff = c - ASCII_ZERO;
		if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_F) begin
			hex_digit = 4'(c - ASCII_UPPER_A + 8'd10);
		end else if (c >= ASCII_LOWER_A && c <= ASCII_LOWER_F) begin
			hex_digit = 4'(c - ASCII_LOWER_A + 8'd10);
		end else begin
			hex_digit = diff[3:0];
		end
	endfunction

endpackage

`default_nettype wire

// File: design/ihex_front.sv
// ----------------------------------------------------------------------------
// ihex_front: character decoder
// Accepts one character a cycle while the queue is not full, tracks the record
// fields and pushes a write command for each data byte.
// ----------------------------------------------------------------------------
`default_nettype none

module ihex_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [7:0]        char_in,
	input  wire logic              queue_full,
	output logic                   push,
	output ihex_pkg::wr_cmd_t      push_cmd
);

	logic                            at_line_start_q;
	logic                            in_record_q;
	logic [ihex_pkg::POS_W-1:0]      char_pos_q;
	logic [7:0]                      byte_count_q;
	logic [15:0]                     record_address_q;
	logic [7:0]                      record_type_q;
	logic [15:0]                     field_acc_q;
	logic [31:0]                     address_offset_q;

	logic                            accept;
	logic                            is_nl;
	logic                            in_body;
	logic [3:0]                      digit;
	logic                            restart;
	logic [15:0]                     acc_next;
	logic [ihex_pkg::POS_W-1:0]      data_pos;
	logic [ihex_pkg::POS_W-2:0]      byte_idx;

	assign in_stall = queue_full;
	assign accept   = in_valid && !queue_full;
	assign is_nl    = char_in == ihex_pkg::ASCII_NL;
	assign in_body  = !is_nl && !at_line_start_q && in_record_q;
	assign digit    = ihex_pkg::hex_digit(char_in);

	assign restart  = char_pos_q == ihex_pkg::POS_COUNT_FIRST
		|| char_pos_q == ihex_pkg::POS_ADDR_FIRST
		|| char_pos_q == ihex_pkg::POS_TYPE_FIRST
		|| char_pos_q == ihex_pkg::POS_DATA_FIRST;
	assign acc_next = restart ? {12'd0, digit} : {field_acc_q[11:0], digit};

	// second digit of each data byte closes a byte
	assign data_pos = char_pos_q - ihex_pkg::POS_DATA_FIRST;
	assign byte_idx = data_pos[ihex_pkg::POS_W-1:1];

	assign push = accept && in_body
		&& char_pos_q >= ihex_pkg::POS_DATA_FIRST
		&& record_type_q == ihex_pkg::REC_DATA
		&& data_pos[0]
		&& byte_idx < {1'b0, byte_count_q};

	always_comb begin
		push_cmd.record_address = record_address_q;
		push_cmd.address_offset = address_offset_q;
		push_cmd.byte_index     = byte_idx[7:0];
		push_cmd.data           = acc_next[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_line_start_q  <= 1'b1;
			in_record_q      <= 1'b0;
			char_pos_q       <= '0;
			byte_count_q     <= '0;
			record_address_q <= '0;
			record_type_q    <= '0;
			field_acc_q      <= '0;
			address_offset_q <= '0;
		end else if (accept) begin
			if (is_nl) begin
				at_line_start_q <= 1'b1;
				in_record_q     <= 1'b0;
				char_pos_q      <= '0;
			end else if (at_line_start_q) begin
				at_line_start_q <= 1'b0;
				in_record_q     <= char_in == ihex_pkg::ASCII_COLON;
				char_pos_q      <= ihex_pkg::POS_COUNT_FIRST;
			end else if (in_record_q) begin
				if (char_pos_q != ihex_pkg::POS_MAX) begin
					char_pos_q <= char_pos_q + 1'b1;
				end
				field_acc_q <= acc_next;
				if (char_pos_q == ihex_pkg::POS_COUNT_LAST) begin
					byte_count_q <= acc_next[7:0];
				end
				if (char_pos_q == ihex_pkg::POS_ADDR_LAST) begin
					record_address_q <= acc_next;
				end
				if (char_pos_q == ihex_pkg::POS_TYPE_LAST) begin
					record_type_q <= acc_next[7:0];
				end
				if (char_pos_q == ihex_pkg::POS_OFFSET_LAST) begin
					unique case (record_type_q)
						ihex_pkg::REC_EXT_SEG: begin
							address_offset_q <= {12'd0, acc_next, 4'd0};
						end
						ihex_pkg::REC_EXT_LIN: begin
							address_offset_q <= {acc_next, 16'd0};
						end
						default: begin
							address_offset_q <= address_offset_q;
						end
					endcase
				end
			end
		end
	end

endmodule

`default_nettype wire

// File: design/ihex_queue.sv
// ----------------------------------------------------------------------------
// ihex_queue: write command queue
// Small register FIFO that decouples the decoder from the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ihex_queue #(
	parameter int unsigned DEPTH = ihex_pkg::QUEUE_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire ihex_pkg::wr_cmd_t push_cmd,
	output logic                   full,
	input  wire logic              pop,
	output logic                   not_empty,
	output ihex_pkg::wr_cmd_t      pop_cmd
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	ihex_pkg::wr_cmd_t    entry_q [DEPTH];
	logic [PTR_W-1:0]     wr_ptr_q;
	logic [PTR_W-1:0]     rd_ptr_q;
	logic [CNT_W-1:0]     count_q;
	logic                 do_push;
	logic                 do_pop;

	assign full      = count_q == CNT_W'(DEPTH);
	assign not_empty = count_q != '0;
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: design/ihex_back.sv
// ----------------------------------------------------------------------------
// ihex_back: write output stage
// Pops a command, forms the full byte address and holds it in the output
// register until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ihex_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cmd_valid,
	input  wire ihex_pkg::wr_cmd_t cmd,
	output logic                   cmd_pop,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [31:0]            write_address,
	output logic [7:0]             write_byte
);

	logic        out_valid_q;
	logic [31:0] write_address_q;
	logic [7:0]  write_byte_q;
	logic [31:0] address_sum;

	// refill whenever the register is empty or being taken
	assign cmd_pop     = cmd_valid && (!out_valid_q || !out_stall);
	assign address_sum = {16'd0, cmd.record_address} + cmd.address_offset
		+ {24'd0, cmd.byte_index};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd_pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			write_address_q <= address_sum;
			write_byte_q    <= cmd.data;
		end
	end

	assign out_valid     = out_valid_q;
	assign write_address = write_address_q;
	assign write_byte    = write_byte_q;

endmodule

`default_nettype wire

// File: design/intel_hex_record_parser.sv
// ----------------------------------------------------------------------------
// intel_hex_record_parser: HEX text stream to byte writes
// Decodes record lines of a HEX text stream and emits one write per data byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one ASCII character per word on char_in, qualified by
//   in_valid; the word is taken on a clock edge with in_valid high and
//   in_stall low. One character can be taken every cycle.
//   Output channel: write_address / write_byte, qualified by out_valid and
//   taken on an edge with out_stall low. Data records give one word per data
//   byte; offset records (types 2 and 4) update the address offset; all
//   other characters give no output.
//   Path: the closing digit of a data byte pushes a command into the queue;
//   the address adder then loads its word from the queue into the output
//   register. Throughput: one character per cycle while in_stall is low;
//   the output stage also moves one word per cycle while out_stall is low.
//   Stalls: a stalled output word holds. Up to QUEUE_DEPTH further writes
//   wait in the queue; when it fills, in_stall rises and the input holds.
//   Reset: arst_n clears the parser to the start of a line with a zero
//   offset and empties the queue and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module intel_hex_record_parser #(
	parameter int unsigned QUEUE_DEPTH = ihex_pkg::QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  char_in,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      write_address,
	output logic [7:0]       write_byte
);

	logic              queue_full;
	logic              push;
	ihex_pkg::wr_cmd_t push_cmd;
	logic              pop;
	logic              queue_not_empty;
	ihex_pkg::wr_cmd_t pop_cmd;

	// decode characters, track fields and offset
	ihex_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.char_in    (char_in),
		.queue_full (queue_full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	// hold pending writes while the receiver stalls
	ihex_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (queue_full),
		.pop       (pop),
		.not_empty (queue_not_empty),
		.pop_cmd   (pop_cmd)
	);

	// add the address parts and drive the output register
	ihex_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (queue_not_empty),
		.cmd           (pop_cmd),
		.cmd_pop       (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.write_address (write_address),
		.write_byte    (write_byte)
	);

endmodule

`default_nettype wire

// File: design/ihex_checker.sv
// ----------------------------------------------------------------------------
// ihex_checker: port-level checks of the HEX record parser
// Output handshake rules and the relation between input and output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module ihex_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [31:0] write_address,
	input wire logic [7:0]  write_byte
);

	a_out_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output word dropped while stalled");

	a_out_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(write_address) && $stable(write_byte))
		else $error("output word changed while stalled");

	// a full queue means the output register is occupied
	a_stall_needs_output: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with an empty output register");

	// the queue only fills while the receiver holds off
	a_stall_from_receiver: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(out_stall) && $past(out_valid))
		else $error("input stall rose without an output stall");

	a_stall_known: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_stall || !out_stall || $past(!out_stall))
		else $error("input stall released inconsistently");

endmodule

bind intel_hex_record_parser ihex_checker u_ihex_checker (.*);

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the HEX record parser
// Feeds character streams into the parser, first a short fixed stream and then
// random record lines with noise and cut-short records, while both sides idle
// and stall at random. The fixed rows carry their writes; a local model of the
// line parser predicts the rest, and each leaving write is checked in order.
// ----------------------------------------------------------------------------

module testbench;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int RANDOM_ITEMS = 1120;
	localparam int LONG_AFTER   = 150;
	localparam int DRAIN_CYCLES = 20;
	localparam int LONG_LINE    = 1040;

	// one row of the fixed stream; a typed write is the word the row must cause
	typedef struct packed {
		logic [7:0]  ch;
		logic        typed;
		logic [31:0] waddr;
		logic [7:0]  wbyte;
	} stim_row_t;

	typedef struct packed {
		logic [31:0] addr;
		logic [7:0]  data;
	} mem_write_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  char_in = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] write_address;
	logic [7:0]  write_byte;

	// typed write that travels along with the word on char_in
	logic        word_typed = 1'b0;
	logic [31:0] word_taddr = 32'h0;
	logic [7:0]  word_tbyte = 8'h0;

	// parser model state
	logic        pr_line_start;
	logic        pr_in_record;
	logic [9:0]  pr_pos;
	logic [7:0]  pr_count;
	logic [15:0] pr_addr;
	logic [7:0]  pr_rec_kind;
	logic [15:0] pr_acc;
	logic [31:0] pr_offset;

	mem_write_t  pending_writes [$];
	logic [7:0]  line_q [$];
	int          err_count = 0;
	int          chars_taken = 0;
	int          cycles = 0;
	int          stall_left = 0;
	int          stall_pick;
	bit          sender_calm = 1'b0;

	logic        got_write;
	logic [31:0] want_addr;
	logic [7:0]  want_byte;
	mem_write_t  want;

	// Fixed stream: a linear offset record with lower-case digits, then a data
	// record whose two bytes land at the top of the address space and wrap to
	// zero. Its first digit pair uses letters that are not hex digits, and the
	// two extreme codes trail as ignored checksum characters.
	stim_row_t stim_rows [30] = '{
		'{":", 1'b0, 32'h0, 8'h0}, '{"0", 1'b0, 32'h0, 8'h0}, '{"0", 1'b0, 32'h0, 8'h0},
		'{"0", 1'b0, 32'h0, 8'h0}, '{"0", 1'b0, 32'h0, 8'h0}, '{"0", 1'b0, 32'h0, 8'h0},
		'{"0", 1'b0, 32'h0, 8'h0}, '{"0", 1'b0, 32'h0, 8'h0}, '{"4", 1'b0, 32'h0, 8'h0},
		'{"f", 1'b0, 32'h0, 8'h0}, '{"f", 1'b0, 32'h0, 8'h0}, '{"f", 1'b0, 32'h0, 8'h0},
		'{"f", 1'b0, 32'h0, 8'h0}, '{"\n", 1'b0, 32'h0, 8'h0},
		'{":", 1'b0, 32'h0, 8'h0}, '{"0", 1'b0, 32'h0, 8'h0}, '{"2", 1'b0, 32'h0, 8'h0},
		'{"F", 1'b0, 32'h0, 8'h0}, '{"F", 1'b0, 32'h0, 8'h0}, '{"F", 1'b0, 32'h0, 8'h0},
		'{"F", 1'b0, 32'h0, 8'h0}, '{"0", 1'b0, 32'h0, 8'h0}, '{"0", 1'b0, 32'h0, 8'h0},
		'{"G", 1'b0, 32'h0, 8'h0}, '{"z", 1'b1, 32'hFFFFFFFF, 8'h7A},
		'{"0", 1'b0, 32'h0, 8'h0}, '{"A", 1'b1, 32'h00000000, 8'h0A},
		'{8'hFF, 1'b0, 32'h0, 8'h0}, '{8'h00, 1'b0, 32'h0, 8'h0}, '{"\n", 1'b0, 32'h0, 8'h0}
	};

	intel_hex_record_parser dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.char_in       (char_in),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.write_address (write_address),
		.write_byte    (write_byte)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Parser model
	// ------------------------------------------------------------------------

	// Letters A..F map to 10..15 in either case; every other code keeps the
	// low nibble of (code - '0'), which is just its own low nibble.
	function automatic logic [3:0] nibble_of(input logic [7:0] c);
		if ((c >= ihex_pkg::ASCII_UPPER_A && c <= ihex_pkg::ASCII_UPPER_F) ||
				(c >= ihex_pkg::ASCII_LOWER_A && c <= ihex_pkg::ASCII_LOWER_F)) begin
			return c[3:0] + 4'd9;
		end
		return c[3:0];
	endfunction

	function automatic void reset_parser();
		pr_line_start = 1'b1;
		pr_in_record  = 1'b0;
		pr_pos        = '0;
		pr_count      = '0;
		pr_addr       = '0;
		pr_rec_kind   = '0;
		pr_acc        = '0;
		pr_offset     = '0;
	endfunction

	// Advance the model by one character; return 1 when it causes a write.
	function automatic logic decode_char(input logic [7:0] c, output logic [31:0] wa,
			output logic [7:0] wb);
		logic [9:0] p;
		logic [3:0] d;
		int         k;
		wa = '0;
		wb = '0;
		if (c == ihex_pkg::ASCII_NL) begin
			pr_line_start = 1'b1;
			pr_in_record  = 1'b0;
			pr_pos        = '0;
			return 1'b0;
		end
		if (pr_line_start) begin
			pr_line_start = 1'b0;
			pr_in_record  = (c == ihex_pkg::ASCII_COLON);
			pr_pos        = ihex_pkg::POS_COUNT_FIRST;
			return 1'b0;
		end
		if (!pr_in_record) begin
			return 1'b0;
		end
		p = pr_pos;
		if (pr_pos < ihex_pkg::POS_MAX) begin
			pr_pos = pr_pos + 10'd1;
		end
		// restart the shift register on the first digit of each field
		d = nibble_of(c);
		if (p == ihex_pkg::POS_COUNT_FIRST || p == ihex_pkg::POS_ADDR_FIRST ||
				p == ihex_pkg::POS_TYPE_FIRST || p == ihex_pkg::POS_DATA_FIRST) begin
			pr_acc = {12'd0, d};
		end else begin
			pr_acc = {pr_acc[11:0], d};
		end
		if (p == ihex_pkg::POS_COUNT_LAST) begin
			pr_count = pr_acc[7:0];
		end else if (p == ihex_pkg::POS_ADDR_LAST) begin
			pr_addr = pr_acc;
		end else if (p == ihex_pkg::POS_TYPE_LAST) begin
			pr_rec_kind = pr_acc[7:0];
		end else if (p >= ihex_pkg::POS_DATA_FIRST) begin
			if (pr_rec_kind == ihex_pkg::REC_DATA) begin
				k = int'(p) - int'(ihex_pkg::POS_DATA_FIRST);
				if (k % 2 == 1 && (k / 2) < int'(pr_count)) begin
					wa = {16'd0, pr_addr} + pr_offset + 32'(k / 2);
					wb = pr_acc[7:0];
					return 1'b1;
				end
			end else if (p == ihex_pkg::POS_OFFSET_LAST) begin
				// the offset moves on the fourth digit, whatever the byte count
				if (pr_rec_kind == ihex_pkg::REC_EXT_SEG) begin
					pr_offset = {12'd0, pr_acc, 4'd0};
				end else if (pr_rec_kind == ihex_pkg::REC_EXT_LIN) begin
					pr_offset = {pr_acc, 16'd0};
				end
			end
		end
		return 1'b0;
	endfunction

	// ------------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------------

	task automatic report_mismatch(input string what);
		$display("ERROR at cycle %0d: %s", cycles, what);
		err_count++;
	endtask

	task automatic check_write(input logic [31:0] got_addr, input logic [7:0] got_byte);
		mem_write_t e;
		if (pending_writes.size() == 0) begin
			report_mismatch($sformatf("write %h <- %h with none pending", got_addr, got_byte));
			return;
		end
		e = pending_writes.pop_front();
		if (got_addr !== e.addr) begin
			report_mismatch($sformatf("write_address %h, want %h", got_addr, e.addr));
		end
		if (got_byte !== e.data) begin
			report_mismatch($sformatf("write_byte %h, want %h (address %h)", got_byte,
				e.data, e.addr));
		end
	endtask

	// Sample both channels on the rising edge. Check the leaving word first;
	// the output is registered, so a word taken now cannot match.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				check_write(write_address, write_byte);
			end
			if (in_valid && !in_stall) begin
				got_write = decode_char(char_in, want_addr, want_byte);
				if (word_typed) begin
					want.addr = word_taddr;
					want.data = word_tbyte;
					pending_writes.push_back(want);
				end else if (got_write) begin
					want.addr = want_addr;
					want.data = want_byte;
					pending_writes.push_back(want);
				end
				chars_taken++;
			end
		end
	end

	// Hard stop for a hung handshake or a write that never comes out.
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Verification failed");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Output stalls: mostly short, a few long, and clear stretches between
	// ------------------------------------------------------------------------

	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
		end else begin
			stall_pick = $urandom_range(0, 99);
			if (stall_pick < 8) begin
				out_stall  <= 1'b0;
				stall_left = $urandom_range(20, 80);
			end else if (stall_pick < 60) begin
				out_stall  <= 1'b0;
			end else if (stall_pick < 95) begin
				out_stall  <= 1'b1;
				stall_left = $urandom_range(0, 2);
			end else begin
				out_stall  <= 1'b1;
				stall_left = $urandom_range(10, 40);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Sender
	// ------------------------------------------------------------------------

	function automatic int pick_gap();
		int r;
		if (sender_calm) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 65) begin
			return 0;
		end else if (r < 93) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// Present one word at a falling edge and hold it until the parser takes it.
	// Drop valid only when a gap comes first, so valid gets one update per step.
	task automatic send_char(input logic [7:0] c, input logic typed, input logic [31:0] ta,
			input logic [7:0] tbyte);
		int gap;
		int target;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   <= 1'b1;
		char_in    <= c;
		word_typed <= typed;
		word_taddr <= ta;
		word_tbyte <= tbyte;
		target = chars_taken + 1;
		do @(negedge clk); while (chars_taken != target);
	endtask

	// Drop valid and hold off until every predicted write has left the block.
	task automatic wait_all_written();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending_writes.size() != 0);
	endtask

	function automatic logic [7:0] any_but_newline();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255)); while (c == ihex_pkg::ASCII_NL);
		return c;
	endfunction

	// One hex digit in random case, now and then replaced by an arbitrary code.
	function automatic logic [7:0] digit_char(input logic [3:0] v);
		if ($urandom_range(0, 99) < 3) begin
			return any_but_newline();
		end
		if (v < 4'd10) begin
			return ihex_pkg::ASCII_ZERO + v;
		end
		return (($urandom_range(0, 1) != 0) ? ihex_pkg::ASCII_UPPER_A :
			ihex_pkg::ASCII_LOWER_A) + v - 8'd10;
	endfunction

	task automatic push_hex(input logic [15:0] v, input int ndig);
		for (int i = ndig - 1; i >= 0; i--) begin
			line_q.push_back(digit_char(v[i*4 +: 4]));
		end
	endtask

	// Build a record line without its newline. used_len counts the characters
	// up to the last field the parser acts on; checksum and tail come after.
	task automatic build_record(input bit long_data, output int used_len);
		int          r;
		logic [7:0]  kind;
		logic [7:0]  count;
		logic [15:0] addr;
		logic [15:0] value;
		r = $urandom_range(0, 99);
		if (long_data || r < 60) begin
			kind = ihex_pkg::REC_DATA;
			r = $urandom_range(0, 99);
			if (long_data) begin
				count = 8'hFF;
			end else if (r < 85) begin
				count = 8'($urandom_range(0, 8));
			end else begin
				count = 8'($urandom_range(9, 40));
			end
		end else if (r < 75) begin
			kind  = ihex_pkg::REC_EXT_SEG;
			count = 8'($urandom_range(0, 255));
		end else if (r < 90) begin
			kind  = ihex_pkg::REC_EXT_LIN;
			count = 8'($urandom_range(0, 255));
		end else begin
			kind  = 8'($urandom_range(0, 255));
			count = 8'($urandom_range(0, 6));
		end
		// bias some addresses to the top of the page to exercise the carry
		if ($urandom_range(0, 99) < 20) begin
			addr = {8'hFF, 8'($urandom_range(0, 255))};
		end else begin
			addr = 16'($urandom_range(0, 65535));
		end
		line_q.push_back(ihex_pkg::ASCII_COLON);
		push_hex({8'd0, count}, 2);
		push_hex(addr, 4);
		push_hex({8'd0, kind}, 2);
		if (kind == ihex_pkg::REC_EXT_SEG || kind == ihex_pkg::REC_EXT_LIN) begin
			r = $urandom_range(0, 99);
			value = (r < 15) ? 16'h0000 : (r < 30) ? 16'hFFFF : 16'($urandom_range(0, 65535));
			push_hex(value, 4);
		end else begin
			for (int i = 0; i < int'(count); i++) begin
				push_hex(16'($urandom_range(0, 255)), 2);
			end
		end
		used_len = line_q.size();
		// checksum, then an optional carriage return or junk tail
		push_hex(16'($urandom_range(0, 255)), 2);
		r = $urandom_range(0, 99);
		if (r < 30) begin
			line_q.push_back("\r");
		end else if (r < 40) begin
			repeat ($urandom_range(1, 5)) line_q.push_back(any_but_newline());
		end
		// pad far past the last position the parser can count to
		if (long_data) begin
			while (line_q.size() < LONG_LINE) begin
				line_q.push_back(digit_char(4'($urandom_range(0, 15))));
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------

	initial begin
		int  used;
		int  sent_chars;
		int  r;
		bit  long_done;
		sent_chars = 0;
		long_done = 1'b0;
		reset_parser();

		// hold reset at the start, release it on a falling edge
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// fixed stream first, then let every write out before going random
		foreach (stim_rows[i]) begin
			send_char(stim_rows[i].ch, stim_rows[i].typed, stim_rows[i].waddr,
				stim_rows[i].wbyte);
		end
		wait_all_written();

		while (sent_chars < RANDOM_ITEMS) begin
			if ($urandom_range(0, 99) < 10) begin
				sender_calm = !sender_calm;
			end
			line_q.delete();
			used = 0;
			r = $urandom_range(0, 99);
			if (!long_done && sent_chars > LONG_AFTER) begin
				// one maximal data record on a line long enough to saturate
				build_record(1'b1, used);
				long_done = 1'b1;
			end else if (r < 72) begin
				build_record(1'b0, used);
			end else if (r < 82) begin
				// record cut short by the newline somewhere inside its fields
				build_record(1'b0, used);
				used = $urandom_range(1, used - 1);
				while (line_q.size() > used) begin
					void'(line_q.pop_back());
				end
			end else if (r < 95) begin
				// non-record line; a later colon means nothing
				line_q.push_back(any_but_newline());
				if (line_q[0] == ihex_pkg::ASCII_COLON) begin
					line_q[0] = "#";
				end
				repeat ($urandom_range(0, 20)) line_q.push_back(any_but_newline());
			end
			line_q.push_back(ihex_pkg::ASCII_NL);
			foreach (line_q[i]) begin
				send_char(line_q[i], 1'b0, 32'h0, 8'h0);
			end
			sent_chars += line_q.size();
			if ($urandom_range(0, 99) < 3) begin
				wait_all_written();
			end
		end

		// drain, then give the pipeline time to show any stray word
		wait_all_written();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// File: intel_hex_record_parser.f
design/ihex_pkg.sv
design/ihex_front.sv
design/ihex_queue.sv
design/ihex_back.sv
design/intel_hex_record_parser.sv
design/ihex_checker.sv
tb/testbench.sv
